FILE: hdl/sle_pkg.sv
// Package for the sorted list engine: operation and status codes, and the
// command/status structs between controller and datapath. No dependencies.
package sle_pkg;

   // Operation codes carried on req_tuser
   localparam logic [1:0] OP_INSERT    = 2'd0;
   localparam logic [1:0] OP_DELETE    = 2'd1;
   localparam logic [1:0] OP_LIST_UP   = 2'd2;
   localparam logic [1:0] OP_LIST_DOWN = 2'd3;

   // Result status codes carried on rsp_tuser
   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_NOT_FOUND = 2'd1;
   localparam logic [1:0] ST_FULL      = 2'd2;
   localparam logic [1:0] ST_EMPTY     = 2'd3;

   // Index register update
   localparam logic [2:0] IDX_HOLD  = 3'd0;
   localparam logic [2:0] IDX_ZERO  = 3'd1;
   localparam logic [2:0] IDX_TOP   = 3'd2;  // count - 1
   localparam logic [2:0] IDX_COUNT = 3'd3;
   localparam logic [2:0] IDX_INC   = 3'd4;
   localparam logic [2:0] IDX_DEC   = 3'd5;

   // Read address, relative to the next index value
   localparam logic [1:0] RA_CUR   = 2'd0;
   localparam logic [1:0] RA_BELOW = 2'd1;
   localparam logic [1:0] RA_ABOVE = 2'd2;

   // Write data source
   localparam logic WD_READ = 1'b0;
   localparam logic WD_ITEM = 1'b1;

   // Result value source
   localparam logic [1:0] SRC_ITEM = 2'd0;
   localparam logic [1:0] SRC_READ = 2'd1;
   localparam logic [1:0] SRC_ZERO = 2'd2;

   typedef struct packed {
      logic       take;
      logic [2:0] idx_sel;
      logic       rd_en;
      logic [1:0] rd_sel;
      logic       wr_en;
      logic       wr_sel;
      logic       cnt_inc;
      logic       cnt_dec;
      logic       rsp_load;
      logic [1:0] rsp_src;
      logic [1:0] rsp_status;
      logic       rsp_last;
   } sle_cmd_type;

   typedef struct packed {
      logic [1:0] op;
      logic       count_zero;
      logic       count_full;
      logic       idx_zero;
      logic       idx_one;
      logic       idx_top;
      logic       key_ge;
      logic       key_eq;
      logic       above_ok;
      logic       above2_ok;
      logic       rsp_free;
   } sle_stat_type;

endpackage

FILE: hdl/sle_datapath.sv
// Datapath of the sorted list engine: value memory, entry count, index
// register, compare logic and the result register. Uses sle_pkg.
module sle_datapath #(
   parameter int CAPACITY = 32
) (
   input  logic               clock,
   input  logic               reset,
   input  sle_pkg::sle_cmd_type  cmd,
   output sle_pkg::sle_stat_type stat,
   input  logic [31:0]        req_tdata,   // item_value
   input  logic [1:0]         req_tuser,   // operation
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output logic [31:0]        rsp_tdata,   // out_value
   output logic [1:0]         rsp_tuser,   // status
   output logic               rsp_tlast    // last_flag
);
   import sle_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = CW + 1;

   logic [31:0]   mem [CAPACITY];
   logic [31:0]   rd_data_ff;
   logic [AW-1:0] rd_addr;
   logic [31:0]   wr_data;

   logic [CW-1:0] count_ff, count_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [1:0]    op_ff;
   logic [31:0]   item_ff;

   logic          rsp_valid_ff, rsp_valid_in;
   logic [31:0]   rsp_value_ff, rsp_value_in;
   logic [1:0]    rsp_status_ff;
   logic          rsp_last_ff;

   logic [EW-1:0] idx_ext, count_ext;

   assign idx_ext   = EW'(idx_ff);
   assign count_ext = EW'(count_ff);

   // Index register update
   always_comb begin
      unique case (cmd.idx_sel)
         IDX_ZERO:  idx_in = '0;
         IDX_TOP:   idx_in = AW'(count_ff - CW'(1));
         IDX_COUNT: idx_in = AW'(count_ff);
         IDX_INC:   idx_in = idx_ff + AW'(1);
         IDX_DEC:   idx_in = idx_ff - AW'(1);
         default:   idx_in = idx_ff;
      endcase
   end

   // Read address relative to the next index
   always_comb begin
      unique case (cmd.rd_sel)
         RA_BELOW: rd_addr = idx_in - AW'(1);
         RA_ABOVE: rd_addr = idx_in + AW'(1);
         default:  rd_addr = idx_in;
      endcase
   end

   assign wr_data = (cmd.wr_sel == WD_ITEM) ? item_ff : rd_data_ff;

   // Value memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[idx_ff] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Entry count
   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_inc) begin
         count_in = count_ff + CW'(1);
      end else if (cmd.cnt_dec) begin
         count_in = count_ff - CW'(1);
      end
   end

   // Result register value select
   always_comb begin
      case (cmd.rsp_src)
         SRC_READ: rsp_value_in = rd_data_ff;
         SRC_ZERO: rsp_value_in = '0;
         default:  rsp_value_in = item_ff;
      endcase
   end

   assign rsp_valid_in = cmd.rsp_load | (rsp_valid_ff & ~rsp_tready);

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      if (cmd.take) begin
         op_ff   <= req_tuser;
         item_ff <= req_tdata;
      end
      if (cmd.rsp_load) begin
         rsp_value_ff  <= rsp_value_in;
         rsp_status_ff <= cmd.rsp_status;
         rsp_last_ff   <= cmd.rsp_last;
      end
   end

   // Status to the controller
   always_comb begin
      stat.op         = op_ff;
      stat.count_zero = (count_ff == '0);
      stat.count_full = (count_ff == CW'(CAPACITY));
      stat.idx_zero   = (idx_ff == '0);
      stat.idx_one    = (idx_ff == AW'(1));
      stat.idx_top    = (idx_ext + EW'(1) == count_ext);
      stat.key_ge     = ($signed(rd_data_ff) >= $signed(item_ff));
      stat.key_eq     = (rd_data_ff == item_ff);
      stat.above_ok   = (idx_ext + EW'(1) < count_ext);
      stat.above2_ok  = (idx_ext + EW'(2) < count_ext);
      stat.rsp_free   = ~rsp_valid_ff | rsp_tready;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_value_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

FILE: hdl/sle_ctrl.sv
// Controller of the sorted list engine: sequences insert, delete and list
// operations by driving datapath commands. Uses sle_pkg.
module sle_ctrl (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [1:0]            req_tuser,
   input  sle_pkg::sle_stat_type stat,
   output sle_pkg::sle_cmd_type  cmd
);
   import sle_pkg::*;

   localparam logic [2:0] S_IDLE      = 3'd0;
   localparam logic [2:0] S_INS_CMP   = 3'd1;
   localparam logic [2:0] S_INS_PUT   = 3'd2;
   localparam logic [2:0] S_DEL_SCAN  = 3'd3;
   localparam logic [2:0] S_DEL_SHIFT = 3'd4;
   localparam logic [2:0] S_LST_OUT   = 3'd5;
   localparam logic [2:0] S_RESULT    = 3'd6;

   logic [2:0] state_ff, state_in;
   logic [1:0] pend_ff, pend_in;
   logic       list_up, at_last;

   assign req_tready = (state_ff == S_IDLE);
   assign list_up    = (stat.op == OP_LIST_UP);
   assign at_last    = list_up ? stat.idx_top : stat.idx_zero;

   always_comb begin
      state_in = state_ff;
      pend_in  = pend_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.take = 1'b1;
               case (req_tuser)
                  OP_INSERT: begin
                     if (stat.count_full) begin
                        pend_in  = ST_FULL;
                        state_in = S_RESULT;
                     end else if (stat.count_zero) begin
                        cmd.idx_sel = IDX_ZERO;
                        state_in    = S_INS_PUT;
                     end else begin
                        cmd.idx_sel = IDX_COUNT;
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = RA_BELOW;
                        state_in    = S_INS_CMP;
                     end
                  end
                  OP_DELETE: begin
                     if (stat.count_zero) begin
                        pend_in  = ST_EMPTY;
                        state_in = S_RESULT;
                     end else begin
                        cmd.idx_sel = IDX_ZERO;
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = RA_CUR;
                        state_in    = S_DEL_SCAN;
                     end
                  end
                  default: begin
                     if (stat.count_zero) begin
                        pend_in  = ST_EMPTY;
                        state_in = S_RESULT;
                     end else begin
                        cmd.idx_sel = (req_tuser == OP_LIST_UP) ? IDX_ZERO : IDX_TOP;
                        cmd.rd_en   = 1'b1;
                        cmd.rd_sel  = RA_CUR;
                        state_in    = S_LST_OUT;
                     end
                  end
               endcase
            end
         end
         // Walk down from the top, moving entries >= item up one place
         S_INS_CMP: begin
            cmd.wr_en = 1'b1;
            if (stat.key_ge) begin
               cmd.wr_sel  = WD_READ;
               cmd.idx_sel = IDX_DEC;
               if (stat.idx_one) begin
                  state_in = S_INS_PUT;
               end else begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RA_BELOW;
               end
            end else begin
               cmd.wr_sel  = WD_ITEM;
               cmd.cnt_inc = 1'b1;
               pend_in     = ST_OK;
               state_in    = S_RESULT;
            end
         end
         S_INS_PUT: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WD_ITEM;
            cmd.cnt_inc = 1'b1;
            pend_in     = ST_OK;
            state_in    = S_RESULT;
         end
         // Search upward for the first equal entry
         S_DEL_SCAN: begin
            if (stat.key_eq) begin
               if (stat.above_ok) begin
                  cmd.rd_en  = 1'b1;
                  cmd.rd_sel = RA_ABOVE;
                  state_in   = S_DEL_SHIFT;
               end else begin
                  cmd.cnt_dec = 1'b1;
                  pend_in     = ST_OK;
                  state_in    = S_RESULT;
               end
            end else if (stat.above_ok) begin
               cmd.idx_sel = IDX_INC;
               cmd.rd_en   = 1'b1;
               cmd.rd_sel  = RA_CUR;
            end else begin
               pend_in  = ST_NOT_FOUND;
               state_in = S_RESULT;
            end
         end
         // Close the gap: entry idx+1 moves to idx
         S_DEL_SHIFT: begin
            cmd.wr_en   = 1'b1;
            cmd.wr_sel  = WD_READ;
            cmd.idx_sel = IDX_INC;
            if (stat.above2_ok) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RA_ABOVE;
            end else begin
               cmd.cnt_dec = 1'b1;
               pend_in     = ST_OK;
               state_in    = S_RESULT;
            end
         end
         // One listed value per transfer slot
         S_LST_OUT: begin
            if (stat.rsp_free) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_src    = SRC_READ;
               cmd.rsp_status = ST_OK;
               cmd.rsp_last   = at_last;
               if (at_last) begin
                  state_in = S_IDLE;
               end else begin
                  cmd.idx_sel = list_up ? IDX_INC : IDX_DEC;
                  cmd.rd_en   = 1'b1;
                  cmd.rd_sel  = RA_CUR;
               end
            end
         end
         S_RESULT: begin
            if (stat.rsp_free) begin
               cmd.rsp_load   = 1'b1;
               cmd.rsp_src    = (stat.op == OP_LIST_UP || stat.op == OP_LIST_DOWN)
                                ? SRC_ZERO : SRC_ITEM;
               cmd.rsp_status = pend_ff;
               cmd.rsp_last   = 1'b1;
               state_in       = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
   end

endmodule

FILE: hdl/sorted_list_engine_top.sv
// Sorted list engine top level: joins the controller and the datapath.
// Depends on sle_pkg, sle_ctrl and sle_datapath.
//
// Usage:
//   The req channel takes one command per transfer: req_tuser is the
//   operation (insert, delete, list ascending, list descending) and
//   req_tdata the signed value. The rsp channel returns results: rsp_tdata
//   is the value, rsp_tuser the status, rsp_tlast marks the final result of
//   a command. Insert and delete give one result; a list gives one result per
//   stored value, or a single empty result when nothing is stored.
//   Commands are handled one at a time; req_tready is high only while the
//   engine waits for a command, including while the last result still waits
//   in the output register.
//   Insert moves each stored entry that is >= the new value up one place,
//   walking down from the top; delete scans upward for the first equal
//   entry, then shifts the entries above it down one place; a list gives
//   one result per cycle while the receiver accepts them. Full and empty
//   results come without a memory access, not found after a full scan.
//   When the receiver stalls, the result register holds its transfer and the
//   engine waits. Reset empties the store; memory contents are not cleared.
module sorted_list_engine_top #(
   parameter int CAPACITY = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // [31:0] item_value
   input  logic [1:0]  req_tuser,   // [1:0] operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [31:0] out_value
   output logic [1:0]  rsp_tuser,   // [1:0] status
   output logic        rsp_tlast    // last_flag
);
   import sle_pkg::*;

   sle_cmd_type  cmd;
   sle_stat_type stat;

   sle_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .stat       (stat),
      .cmd        (cmd)
   );

   sle_datapath #(
      .CAPACITY (CAPACITY)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

endmodule
